@@ sv/assert_macros.svh @@
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// consequence holds in the same cycle as the trigger
`define ASSERT_IMPLIES(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error("assertion failed");

// consequence holds in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ sv/b64n_pkg.sv @@
// types, status codes and alphabet lookup for the base64url nonce decoder
package b64n_pkg;

	// verdict reported with the last character
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_CHAR  = 3'd1,
		ST_TOO_MANY  = 3'd2,
		ST_TOO_LONG  = 3'd3,
		ST_TRAILING  = 3'd4,
		ST_WRONG_LEN = 3'd5,
		ST_ALL_ZERO  = 3'd6
	} status_t;

	// one decoded character: in-alphabet flag and its 6-bit value
	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sextet_t;

	// one result item
	typedef struct packed {
		logic [7:0] byte_value;
		logic       byte_valid;
		logic       end_of_string;
		status_t    status;
	} result_t;

	// alphabet code points
	localparam logic [15:0] CH_UPPER_A = 16'h0041;
	localparam logic [15:0] CH_UPPER_Z = 16'h005A;
	localparam logic [15:0] CH_LOWER_A = 16'h0061;
	localparam logic [15:0] CH_LOWER_Z = 16'h007A;
	localparam logic [15:0] CH_DIGIT_0 = 16'h0030;
	localparam logic [15:0] CH_DIGIT_9 = 16'h0039;
	localparam logic [15:0] CH_DASH    = 16'h002D;
	localparam logic [15:0] CH_USCORE  = 16'h005F;

	// base values of each alphabet range
	localparam logic [15:0] BASE_LOWER = 16'd26;
	localparam logic [15:0] BASE_DIGIT = 16'd52;
	localparam logic [5:0]  VAL_DASH   = 6'd62;
	localparam logic [5:0]  VAL_USCORE = 6'd63;

	// map a code unit onto the base64url alphabet
	function automatic sextet_t sextet_of(input logic [15:0] c);
		sextet_t s;
		s.ok  = 1'b1;
		s.val = '0;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			s.val = 6'(c - CH_UPPER_A);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			s.val = 6'(c - CH_LOWER_A + BASE_LOWER);
		end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			s.val = 6'(c - CH_DIGIT_0 + BASE_DIGIT);
		end else if (c == CH_DASH) begin
			s.val = VAL_DASH;
		end else if (c == CH_USCORE) begin
			s.val = VAL_USCORE;
		end else begin
			s.ok = 1'b0;
		end
		return s;
	endfunction

endpackage

@@ sv/b64n_core.sv @@
// per-character decode state and next-state logic of the nonce decoder
`include "assert_macros.svh"

module b64n_core #(
	parameter int NONCE_BYTES = 16,
	parameter int MAX_CHARS   = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [15:0]       char_code,
	input  logic              last_char,
	output b64n_pkg::result_t res
);
	import b64n_pkg::*;

	localparam int BW = $clog2(NONCE_BYTES + 2);
	localparam int CW = $clog2(MAX_CHARS + 2);
	localparam logic [BW-1:0] BYTES_FULL = BW'(NONCE_BYTES);
	localparam logic [BW-1:0] BYTES_OVER = BW'(NONCE_BYTES + 1);
	localparam logic [CW-1:0] CHARS_MAX  = CW'(MAX_CHARS);

	logic [5:0]    pend_bits_q;
	logic [2:0]    pend_cnt_q;
	logic [BW-1:0] bytes_q;
	logic [CW-1:0] chars_q;
	logic          nonzero_q;
	status_t       err_q;

	logic [5:0]    bits_d;
	logic [2:0]    cnt_d;
	logic [BW-1:0] bytes_d;
	logic [CW-1:0] chars_d;
	logic          nz_d;
	status_t       err_d;

	sextet_t       sx;
	logic [11:0]   acc;
	logic [11:0]   acc_sh;
	logic [3:0]    cnt_sum;
	logic [2:0]    cnt_new;
	logic [7:0]    dec_byte;

	// decode one character against the running state
	always_comb begin
		sx       = sextet_of(char_code);
		acc      = {pend_bits_q, sx.val};
		cnt_sum  = {1'b0, pend_cnt_q} + 4'd6;
		// low bits are the leftover count whether or not a byte leaves
		cnt_new  = cnt_sum[2:0];
		acc_sh   = acc >> cnt_new;
		dec_byte = acc_sh[7:0];

		chars_d = chars_q + CW'(chars_q <= CHARS_MAX);
		err_d   = err_q;
		bits_d  = pend_bits_q;
		cnt_d   = pend_cnt_q;
		bytes_d = bytes_q;
		nz_d    = nonzero_q;
		res     = '0;

		// length limit is checked ahead of the alphabet
		if (err_q == ST_OK && chars_d > CHARS_MAX) begin
			err_d = ST_TOO_LONG;
		end

		if (err_d == ST_OK) begin
			if (!sx.ok) begin
				err_d = ST_BAD_CHAR;
			end else begin
				if (cnt_sum[3]) begin
					if (bytes_q >= BYTES_FULL) begin
						err_d   = ST_TOO_MANY;
						bytes_d = BYTES_OVER;
					end else begin
						bytes_d        = bytes_q + BW'(1);
						res.byte_value = dec_byte;
						res.byte_valid = 1'b1;
						if (dec_byte != 8'd0) begin
							nz_d = 1'b1;
						end
					end
				end
				cnt_d  = cnt_new;
				bits_d = acc[5:0] & ~(6'h3f << cnt_new);
			end
		end

		// verdict on the last character
		res.end_of_string = last_char;
		if (last_char) begin
			if (err_d != ST_OK) begin
				res.status = err_d;
			end else if (cnt_d != 3'd0 && bits_d != 6'd0) begin
				res.status = ST_TRAILING;
			end else if (bytes_d != BYTES_FULL) begin
				res.status = ST_WRONG_LEN;
			end else if (!nz_d) begin
				res.status = ST_ALL_ZERO;
			end else begin
				res.status = ST_OK;
			end
		end
	end

	// state update, cleared after each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
			bytes_q     <= '0;
			chars_q     <= '0;
			nonzero_q   <= 1'b0;
			err_q       <= ST_OK;
		end else if (adv) begin
			if (last_char) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
				bytes_q     <= '0;
				chars_q     <= '0;
				nonzero_q   <= 1'b0;
				err_q       <= ST_OK;
			end else begin
				pend_bits_q <= bits_d;
				pend_cnt_q  <= cnt_d;
				bytes_q     <= bytes_d;
				chars_q     <= chars_d;
				nonzero_q   <= nz_d;
				err_q       <= err_d;
			end
		end
	end

	// leftover count is always 0, 2, 4 or 6
	`ASSERT_ALWAYS(a_pend_even, clk, arst_n, !pend_cnt_q[0] && pend_cnt_q <= 3'd6)
	// byte count never passes its saturation point
	`ASSERT_ALWAYS(a_bytes_bound, clk, arst_n, bytes_q <= BYTES_OVER)
	// once an error is latched no byte leaves
	`ASSERT_IMPLIES(a_no_byte_after_err, clk, arst_n, adv && err_q != ST_OK, !res.byte_valid)
	// last character leaves a clean state behind
	`ASSERT_NEXT(a_clear_after_last, clk, arst_n, adv && last_char,
		err_q == ST_OK && bytes_q == '0 && chars_q == '0 && pend_cnt_q == '0)

endmodule

@@ sv/base64url_nonce_decoder.sv @@
// top level of the unpadded base64url nonce decoder
// Usage:
//   Input channel (in_valid / in_stall) takes one UTF-16 code unit per item
//   in char_code, with last_char set on the final character of a string.
//   Output channel (out_valid / out_stall) gives one result item per input
//   item: byte_value with byte_valid when a byte was decoded, and on the
//   last character end_of_string with the verdict in status.
//   Data path: an accepted item enters the input register, is decoded and
//   lands in the result register once that register is free, and its
//   result is presented from there.
//   Throughput: one item per cycle unless out_stall holds; decode state
//   (leftover bits, byte and character counts, error code) updates per item.
//   Stall: while a result waits under out_stall one more item is taken into
//   the input register; in_stall rises only when both registers are full.
//   Reset: arst_n clears both valid flags and all decode state; after the
//   last character of a string the state also returns to its reset value.
module base64url_nonce_decoder #(
	parameter int NONCE_BYTES = 16,
	parameter int MAX_CHARS   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] char_code,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  byte_value,
	output logic        byte_valid,
	output logic        end_of_string,
	output logic [2:0]  status
);
	import b64n_pkg::*;

	logic        valid_s1;
	logic [15:0] char_s1;
	logic        last_s1;
	logic        valid_s2;
	result_t     res_s2;
	result_t     res;
	logic        out_free;
	logic        adv;

	// pipeline flow
	assign out_free = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	// decode state and next-state logic
	b64n_core #(
		.NONCE_BYTES(NONCE_BYTES),
		.MAX_CHARS  (MAX_CHARS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.char_code(char_s1),
		.last_char(last_s1),
		.res      (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	// result ports
	assign out_valid     = valid_s2;
	assign byte_value    = res_s2.byte_value;
	assign byte_valid    = res_s2.byte_valid;
	assign end_of_string = res_s2.end_of_string;
	assign status        = res_s2.status;

endmodule

@@ bench/tb_base64url_nonce_decoder.sv @@
// testbench for the base64url nonce decoder: directed and random strings against a tracked decode
`timescale 1ns / 100ps

module tb_base64url_nonce_decoder;
	import b64n_pkg::*;

	localparam int NONCE_LEN  = 16;
	localparam int CHAR_LIMIT = 64;
	localparam int RUN_LIMIT  = 200000;
	localparam int PHASE_ITEMS = 384;

	// kinds of encoded strings sent in the random part
	typedef enum int {
		K_NONCE, K_ZERO, K_TAIL, K_SHORT, K_LONG, K_OVERLONG, K_BAD, K_NOISE, K_BAD_LAST,
		K_COUNT
	} str_kind_t;

	// one decoder result as the block should give it
	typedef struct {
		logic [7:0] value;
		logic       valid;
		logic       eos;
		status_t    st;
	} decoded_t;

	// tracks the decode state and holds the results still to come
	class nonce_tracker;
		logic [5:0]  pend_bits;
		logic [2:0]  pend_cnt;
		int unsigned nbytes;
		int unsigned nchars;
		bit          nonzero;
		status_t     err;
		decoded_t    decoded_q[$];
		int unsigned mismatches;

		function new();
			clear();
			mismatches = 0;
		endfunction

		function void clear();
			pend_bits = '0;
			pend_cnt  = '0;
			nbytes    = 0;
			nchars    = 0;
			nonzero   = 1'b0;
			err       = ST_OK;
		endfunction

		// position of a code unit in the alphabet, -1 when outside
		function int alpha_index(logic [15:0] c);
			if (c >= 16'h0041 && c <= 16'h005A) return int'(c - 16'h0041);
			if (c >= 16'h0061 && c <= 16'h007A) return int'(c - 16'h0061) + 26;
			if (c >= 16'h0030 && c <= 16'h0039) return int'(c - 16'h0030) + 52;
			if (c == 16'h002D) return 62;
			if (c == 16'h005F) return 63;
			return -1;
		endfunction

		function int unsigned pending();
			return decoded_q.size();
		endfunction

		// decode one accepted character and queue the result it causes
		function void take_char(logic [15:0] c, logic lst);
			decoded_t    e;
			int          v;
			logic [11:0] acc;
			int          cnt;
			logic [7:0]  b;
			e.value = 8'h00;
			e.valid = 1'b0;
			e.eos   = lst;
			e.st    = ST_OK;
			if (nchars <= CHAR_LIMIT) nchars++;
			// overlong strings are flagged before the character itself
			if (err == ST_OK && nchars > CHAR_LIMIT) err = ST_TOO_LONG;
			if (err == ST_OK) begin
				v = alpha_index(c);
				if (v < 0) begin
					err = ST_BAD_CHAR;
				end else begin
					acc = {pend_bits, 6'(v)};
					cnt = int'(pend_cnt) + 6;
					if (cnt >= 8) begin
						cnt -= 8;
						b = 8'(acc >> cnt);
						// the byte past the nonce length is held back
						if (nbytes + 1 > NONCE_LEN) begin
							err = ST_TOO_MANY;
							nbytes = NONCE_LEN + 1;
						end else begin
							nbytes++;
							e.value = b;
							e.valid = 1'b1;
							if (b != 8'h00) nonzero = 1'b1;
						end
					end
					pend_cnt  = 3'(cnt);
					pend_bits = 6'(acc & ((12'd1 << cnt) - 12'd1));
				end
			end
			// verdict on the last character, then a fresh string
			if (lst) begin
				if (err != ST_OK) e.st = err;
				else if (pend_cnt != 0 && pend_bits != 0) e.st = ST_TRAILING;
				else if (nbytes != NONCE_LEN) e.st = ST_WRONG_LEN;
				else if (!nonzero) e.st = ST_ALL_ZERO;
				else e.st = ST_OK;
				clear();
			end
			decoded_q.push_back(e);
		endfunction

		// compare one result item with the oldest one queued
		function void match_result(logic [7:0] value, logic valid, logic eos, logic [2:0] st);
			decoded_t e;
			if (decoded_q.size() == 0) begin
				$error("unexpected result: byte_value %0h byte_valid %0b", value, valid);
				mismatches++;
				return;
			end
			e = decoded_q.pop_front();
			if (value !== e.value) begin
				$error("byte_value: expected %0h, got %0h", e.value, value);
				mismatches++;
			end
			if (valid !== e.valid) begin
				$error("byte_valid: expected %0b, got %0b", e.valid, valid);
				mismatches++;
			end
			if (eos !== e.eos) begin
				$error("end_of_string: expected %0b, got %0b", e.eos, eos);
				mismatches++;
			end
			if (st !== e.st) begin
				$error("status: expected %0d, got %0d", e.st, st);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [15:0] char_code = 16'h0000;
	logic        last_char = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  byte_value;
	logic        byte_valid;
	logic        end_of_string;
	logic [2:0]  status;

	nonce_tracker chk = new();
	logic [15:0]  text[$];
	int           snd_idle = 0;
	int           rcv_idle = 0;
	int unsigned  sent = 0;
	int unsigned  cycles = 0;

	base64url_nonce_decoder #(
		.NONCE_BYTES(NONCE_LEN),
		.MAX_CHARS(CHAR_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.byte_value(byte_value),
		.byte_valid(byte_valid),
		.end_of_string(end_of_string),
		.status(status)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// receiver stalls at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rcv_idle);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			chk.match_result(byte_value, byte_valid, end_of_string, status);
	end

	// alphabet character for a 6-bit value
	function automatic logic [15:0] code_of(logic [5:0] v);
		if (v < 26) return 16'h0041 + 16'(v);
		if (v < 52) return 16'h0061 + 16'(v - 26);
		if (v < 62) return 16'h0030 + 16'(v - 52);
		if (v == 62) return 16'h002D;
		return 16'h005F;
	endfunction

	// a code unit outside the alphabet, often one next to a range edge
	function automatic logic [15:0] off_alphabet();
		logic [15:0] c;
		do begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 9))
					0: c = 16'h002C;
					1: c = 16'h002E;
					2: c = 16'h002F;
					3: c = 16'h003A;
					4: c = 16'h0040;
					5: c = 16'h005B;
					6: c = 16'h005E;
					7: c = 16'h0060;
					8: c = 16'h007B;
					default: c = 16'hFFFF;
				endcase
			end else begin
				c = 16'($urandom);
			end
		end while (chk.alpha_index(c) >= 0);
		return c;
	endfunction

	// encode a full nonce, optionally all zero or with nonzero tail bits
	function automatic void build_nonce(bit zero, bit spoil_tail);
		logic [131:0] stream;
		stream = '0;
		for (int i = 0; i < NONCE_LEN; i++)
			stream[131 - 8 * i -: 8] = zero ? 8'h00 : 8'($urandom_range(0, 255));
		if (spoil_tail) stream[3:0] = 4'($urandom_range(1, 15));
		text.delete();
		for (int g = 0; g < 22; g++)
			text.push_back(code_of(stream[131 - 6 * g -: 6]));
	endfunction

	// random alphabet text of a given length
	function automatic void build_alpha(int n);
		text.delete();
		for (int i = 0; i < n; i++)
			text.push_back(code_of(6'($urandom_range(0, 63))));
	endfunction

	// present one item and wait until it is taken
	task automatic send_char(input logic [15:0] code, input logic lst);
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= code;
		last_char <= lst;
		do @(posedge clk); while (in_stall);
		chk.take_char(code, lst);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_text();
		foreach (text[i]) send_char(text[i], i == text.size() - 1);
	endtask

	// hold the sender off until every queued result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (chk.pending() != 0) @(negedge clk);
	endtask

	// one random string of the chosen kind
	task automatic send_random_string(str_kind_t kind);
		int pos;
		case (kind)
			K_NONCE:    build_nonce(1'b0, 1'b0);
			K_ZERO:     build_nonce(1'b1, 1'b0);
			K_TAIL:     build_nonce(1'b0, 1'b1);
			K_SHORT:    build_alpha($urandom_range(1, 21));
			K_LONG:     build_alpha($urandom_range(23, 40));
			K_OVERLONG: begin
				build_alpha($urandom_range(CHAR_LIMIT + 1, 130));
				if ($urandom_range(0, 1)) text[$urandom_range(0, 20)] = off_alphabet();
			end
			K_BAD: begin
				build_nonce(1'b0, 1'b0);
				pos = $urandom_range(0, 21);
				text[pos] = off_alphabet();
			end
			K_NOISE: begin
				text.delete();
				for (int i = $urandom_range(1, 30); i > 0; i--)
					text.push_back(16'($urandom));
			end
			default: begin
				build_nonce(1'b0, 1'b0);
				text[21] = off_alphabet();
			end
		endcase
		send_text();
	endtask

	function automatic str_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return K_NONCE;
		if (r < 42) return K_ZERO;
		if (r < 52) return K_TAIL;
		if (r < 64) return K_SHORT;
		if (r < 72) return K_LONG;
		if (r < 74) return K_OVERLONG;
		if (r < 86) return K_BAD;
		if (r < 94) return K_NOISE;
		return K_BAD_LAST;
	endfunction

	// stimulus
	initial begin
		int unsigned strings;
		strings = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		snd_idle = 17;
		rcv_idle = 60;

		// alphabet range edges in one string
		text = '{16'h0041, 16'h005A, 16'h0061, 16'h007A, 16'h0030, 16'h0039,
			16'h002D, 16'h005F};
		send_text();
		// single characters just outside the ranges and the code unit extremes
		text = '{16'h0000, 16'hFFFF, 16'h0040, 16'h005B, 16'h0060, 16'h007B,
			16'h002F, 16'h003A, 16'h002C, 16'h002E, 16'h005E};
		foreach (text[i]) send_char(text[i], 1'b1);
		// lone full-sextet character and a two-character string with tail bits
		send_char(16'h0041, 1'b1);
		send_char(16'h005F, 1'b0);
		send_char(16'h005F, 1'b1);

		// three idle profiles, every kind of string forced first
		for (int phase = 0; phase < 3; phase++) begin
			drain();
			snd_idle = (phase == 0) ? 17 : (phase == 1) ? 60 : 0;
			rcv_idle = (phase == 0) ? 60 : (phase == 1) ? 17 : 0;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				send_random_string((strings < K_COUNT) ? str_kind_t'(strings) : pick_kind());
				strings++;
				if ($urandom_range(0, 15) == 0) drain();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (chk.pending() != 0) begin
			$error("%0d results never arrived", chk.pending());
			chk.mismatches++;
		end
		if (chk.mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/b64n_pkg.sv
sv/b64n_core.sv
sv/base64url_nonce_decoder.sv
bench/tb_base64url_nonce_decoder.sv
